>>> design/lmet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmet_pkg;

  // Window geometry: an 11 by 11 neighbourhood around the output position.
  localparam int RADIUS = 5;
  localparam int SPAN   = 2 * RADIUS + 1;
  localparam int TAPS   = SPAN - 1;

  // Field and register widths.
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 21;
  localparam int IDX_W  = 2;
  localparam int MODE_W = 3;
  localparam int THR_W  = 21;
  localparam int SIZE_W = 11;

  // Accumulator width; covers every mask response and three times the threshold.
  localparam int SUM_W = 25;

  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FOUR   = 3'd0,
    MODE_EIGHT  = 3'd1,
    MODE_MINVAR = 3'd2,
    MODE_LOG    = 3'd3,
    MODE_DOG    = 3'd4
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE      = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_WIDTH     = 2'd2,
    REG_HEIGHT    = 2'd3
  } reg_idx_t;

  // Upper half of the Laplacian-of-Gaussian mask; the lower half mirrors it.
  localparam int LOG_HALF [6][11] = '{
    '{ 0,  0,   0,  -1,  -1,  -2,  -1,  -1,   0,  0,  0},
    '{ 0,  0,  -2,  -4,  -8,  -9,  -8,  -4,  -2,  0,  0},
    '{ 0, -2,  -7, -15, -22, -23, -22, -15,  -7, -2,  0},
    '{-1, -4, -15, -24, -14,  -1, -14, -24, -15, -4, -1},
    '{-1, -8, -22, -14,  52, 103,  52, -14, -22, -8, -1},
    '{-2, -9, -23,  -1, 103, 178, 103,  -1, -23, -9, -2}
  };

  // Upper half of the difference-of-Gaussians mask.
  localparam int DOG_HALF [6][11] = '{
    '{-1,  -3,  -4,  -6,  -7,  -8,  -7,  -6,  -4,  -3, -1},
    '{-3,  -5,  -8, -11, -13, -13, -13, -11,  -8,  -5, -3},
    '{-4,  -8, -12, -16, -17, -17, -17, -16, -12,  -8, -4},
    '{-6, -11, -16, -16,   0,  15,   0, -16, -16, -11, -6},
    '{-7, -13, -17,   0,  85, 160,  85,   0, -17, -13, -7},
    '{-8, -13, -17,  15, 160, 283, 160,  15, -17, -13, -8}
  };

  // The three 3x3 masks: four-neighbour, eight-neighbour, minimum variance.
  localparam int SMALL_MASK [3][3][3] = '{
    '{'{0,  1, 0}, '{ 1, -4,  1}, '{0,  1, 0}},
    '{'{1,  1, 1}, '{ 1, -8,  1}, '{1,  1, 1}},
    '{'{2, -1, 2}, '{-1, -4, -1}, '{2, -1, 2}}
  };

  function automatic int mirror_row(int i);
    return (i <= RADIUS) ? i : (SPAN - 1 - i);
  endfunction

  function automatic int log_coef(int i, int j);
    return LOG_HALF[mirror_row(i)][j];
  endfunction

  function automatic int dog_coef(int i, int j);
    return DOG_HALF[mirror_row(i)][j];
  endfunction

endpackage

`default_nettype wire

>>> design/lmet_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Pixel channel: a grey pixel or a drain tick.
interface lmet_in_if;
  import lmet_pkg::*;

  logic valid;
  logic ready;
  logic req_type;
  pix_t pixel;

  modport source (output valid, output req_type, output pixel, input ready);
  modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

// Result channel: one binary edge pixel.
interface lmet_out_if;
  logic valid;
  logic ready;
  logic edge_white;
  logic frame_last;

  modport source (output valid, output edge_white, output frame_last, input ready);
  modport sink   (input valid, input edge_white, input frame_last, output ready);
endinterface

`default_nettype wire

>>> design/laplacian_mask_edge_threshold_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                 Transfer
// pixels    in         req_type, pixel         valid & ready at rising clk
// edges     out        edge_white, frame_last  valid & ready at rising clk
// cfg_*     in         cfg_index, cfg_wdata    cfg_wen at rising clk
//
// One transfer on pixels is taken in every cycle while the output side keeps
// up and no fill is running; a result travels from the transfer to edges through the
// line-memory read, column shift, window clamp, row sums, final sum and compare.
// A frame smaller than the lag of RADIUS rows plus RADIUS pixels holds
// pixels.ready low after its last pixel until the lag is made up, while the
// column generator runs ahead over the replicated border.
// rst is synchronous; it clears the counters, pipeline and output valids and loads the configuration defaults.
// A two-entry output stage (output register plus skid) absorbs a stall on
// edges; pixels.ready is low while the skid holds a result or a fill runs.

module laplacian_mask_edge_threshold_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  lmet_in_if.sink                     pixels,
  lmet_out_if.source                  edges,
  input  logic                        cfg_wen,
  input  logic [lmet_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lmet_pkg::CFG_W-1:0]  cfg_wdata
);
  import lmet_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int FW_W   = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int FH_W   = $clog2(MAX_HEIGHT + 1);
  localparam int GROW_W = $clog2(MAX_HEIGHT + 2 * SPAN);
  localparam int RECV_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int WORD_W = TAPS * PIX_W;

  // Frame size as used: zero acts as one, and sizes clamp to the maximum.
  function automatic int lim_size(logic [SIZE_W-1:0] v, int maxv);
    if (v == '0) begin
      return 1;
    end
    return (int'(v) > maxv) ? maxv : int'(v);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [MODE_W-1:0] mode_r;
  logic [THR_W-1:0]  thr_r;
  logic [SIZE_W-1:0] img_w;
  logic [SIZE_W-1:0] img_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r <= MODE_W'(MODE_FOUR);
      thr_r  <= THR_W'(18);
      img_w  <= SIZE_W'(512);
      img_h  <= SIZE_W'(512);
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:      mode_r <= cfg_wdata[MODE_W-1:0];
        REG_THRESHOLD: thr_r  <= cfg_wdata[THR_W-1:0];
        REG_WIDTH:     img_w  <= cfg_wdata[SIZE_W-1:0];
        REG_HEIGHT:    img_h  <= cfg_wdata[SIZE_W-1:0];
        default:       mode_r <= mode_r;
      endcase
    end
  end

  // Reserved mode codes behave as the four-neighbour mask.
  mode_t m_eff;
  assign m_eff = (mode_r > MODE_W'(MODE_DOG)) ? MODE_FOUR : mode_t'(mode_r);

  // ---------------------------------------------------------------------
  // Output register and skid; en advances the whole datapath.
  // While fill_left is non-zero the generator advances on its own and no
  // transfer on pixels is taken.
  // ---------------------------------------------------------------------
  logic ov, od_white, od_last;
  logic sv, sd_white, sd_last;
  logic en;
  logic v5, r_white, r_last;
  logic [RECV_W-1:0] fill_left;
  logic              filling, fill_step;

  assign en            = !sv;
  assign filling       = (fill_left != '0);
  assign fill_step     = en && filling;
  assign pixels.ready  = en && !filling;
  assign edges.valid   = ov;
  assign edges.edge_white = od_white;
  assign edges.frame_last = od_last;

  logic acc;
  assign acc = pixels.valid && pixels.ready;

  // ---------------------------------------------------------------------
  // Stage 0: frame counters, decided on the transfer itself.
  // in_* follow the received pixels, gen_* the column generator (which also
  // advances on a drain tick and on a fill cycle), out_* the next output
  // position.
  // ---------------------------------------------------------------------
  logic [FW_W-1:0]   fw;
  logic [FH_W-1:0]   fh;
  logic [COL_W-1:0]  in_col, gen_col, out_col;
  logic [ROW_W-1:0]  in_row, out_row;
  logic [GROW_W-1:0] gen_row;
  logic [RECV_W-1:0] recv;
  logic              in_done;

  logic              take_pix, start, drain_emit, adv, emit, frame_last;
  logic [FW_W-1:0]   fw_use;
  logic [FH_W-1:0]   fh_use;
  logic [RECV_W-1:0] lag_use, recv_inc;
  logic              in_col_wrap, in_row_wrap, gen_col_wrap, out_col_wrap;

  always_comb begin
    take_pix   = !pixels.req_type && !in_done;
    start      = take_pix && (in_row == '0) && (in_col == '0);
    fw_use     = start ? FW_W'(lim_size(img_w, MAX_WIDTH)) : fw;
    fh_use     = start ? FH_W'(lim_size(img_h, MAX_HEIGHT)) : fh;
    drain_emit = pixels.req_type && in_done;
    adv        = take_pix || drain_emit;
    // Results lag the input by RADIUS rows plus RADIUS pixels.
    lag_use    = (RECV_W'(fw_use) << 2) + RECV_W'(fw_use) + RECV_W'(RADIUS);
    recv_inc   = recv + RECV_W'(1);
    emit       = (take_pix && (recv_inc > lag_use)) || drain_emit;

    in_col_wrap  = (FW_W'(in_col) + FW_W'(1)) >= fw_use;
    in_row_wrap  = (FH_W'(in_row) + FH_W'(1)) >= fh_use;
    gen_col_wrap = (FW_W'(gen_col) + FW_W'(1)) >= fw_use;
    out_col_wrap = (FW_W'(out_col) + FW_W'(1)) >= fw_use;
    frame_last   = emit && out_col_wrap && ((FH_W'(out_row) + FH_W'(1)) >= fh_use);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw        <= FW_W'(lim_size(SIZE_W'(512), MAX_WIDTH));
      fh        <= FH_W'(lim_size(SIZE_W'(512), MAX_HEIGHT));
      in_col    <= '0;
      in_row    <= '0;
      in_done   <= 1'b0;
      recv      <= '0;
      gen_col   <= '0;
      gen_row   <= '0;
      out_col   <= '0;
      out_row   <= '0;
      fill_left <= '0;
    end else if (fill_step) begin
      fill_left <= fill_left - RECV_W'(1);
      if (gen_col_wrap) begin
        gen_col <= '0;
        gen_row <= gen_row + GROW_W'(1);
      end else begin
        gen_col <= gen_col + COL_W'(1);
      end
    end else if (acc) begin
      if (start) begin
        fw <= fw_use;
        fh <= fh_use;
      end
      if (take_pix) begin
        recv <= recv_inc;
        if (in_col_wrap) begin
          in_col <= '0;
          if (in_row_wrap) begin
            in_row  <= '0;
            in_done <= 1'b1;
            // A frame shorter than the lag leaves the generator behind the
            // first output position; it catches up before the drain ticks.
            if (recv_inc < lag_use) begin
              fill_left <= lag_use - recv_inc;
            end
          end else begin
            in_row <= in_row + ROW_W'(1);
          end
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (adv) begin
        if (gen_col_wrap) begin
          gen_col <= '0;
          gen_row <= gen_row + GROW_W'(1);
        end else begin
          gen_col <= gen_col + COL_W'(1);
        end
      end
      if (emit) begin
        if (out_col_wrap) begin
          out_col <= '0;
          out_row <= out_row + ROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
      // After the last output of a frame everything starts afresh.
      if (frame_last) begin
        in_col  <= '0;
        in_row  <= '0;
        in_done <= 1'b0;
        recv    <= '0;
        gen_col <= '0;
        gen_row <= '0;
        out_col <= '0;
        out_row <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline valids.
  // ---------------------------------------------------------------------
  logic v1_adv, v1_emit, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1_adv  <= 1'b0;
      v1_emit <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      v5      <= 1'b0;
    end else if (en) begin
      v1_adv  <= (acc && adv) || fill_step;
      v1_emit <= acc && emit;
      v2      <= v1_emit;
      v3      <= v2;
      v4      <= v3;
      v5      <= v4;
    end
  end

  // ---------------------------------------------------------------------
  // Line memory: one word per column holding the ten previous rows, newest
  // in the low byte. Read on a transfer or fill step, written back shifted when
  // stage 1 advances; a same-column write on the edge of the read is forwarded.
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0] line_mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_word, byp_word, word1, wr_word;
  logic              byp_hit, wr_en;

  pix_t              pix1;
  logic [COL_W-1:0]  gcol1, c0_1;
  logic [GROW_W-1:0] grow1;
  logic [FW_W-1:0]   fw1;
  logic [FH_W-1:0]   fh1;
  logic              last1;

  assign word1   = byp_hit ? byp_word : rd_word;
  assign wr_word = {word1[WORD_W-PIX_W-1:0], pix1};
  assign wr_en   = en && v1_adv;

  always_ff @(posedge clk) begin
    if (acc || fill_step) begin
      rd_word  <= line_mem[gen_col];
      byp_hit  <= wr_en && (gcol1 == gen_col);
      byp_word <= wr_word;
    end
    if (wr_en) begin
      line_mem[gcol1] <= wr_word;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: assemble the vertical column for the generator position,
  // replicating the top and bottom rows where the window leaves the image.
  // ---------------------------------------------------------------------
  pix_t tap  [SPAN];
  pix_t vcol [SPAN];

  always_comb begin
    tap[0] = pix1;
    for (int k = 1; k < SPAN; k++) begin
      tap[k] = word1[PIX_W*(k-1) +: PIX_W];
    end
    vcol[RADIUS] = tap[TAPS-RADIUS];
    for (int i = RADIUS - 1; i >= 0; i--) begin
      vcol[i] = (int'(grow1) < TAPS - i) ? vcol[i+1] : tap[TAPS-i];
    end
    for (int i = RADIUS + 1; i < SPAN; i++) begin
      vcol[i] = (int'(grow1) + i > int'(fh1) + TAPS - 1) ? vcol[i-1] : tap[TAPS-i];
    end
  end

  // Eleven most recent columns, in raster order of their positions.
  pix_t colsh [SPAN][SPAN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int j = 0; j < SPAN - 1; j++) begin
        colsh[j] <= colsh[j+1];
      end
      colsh[SPAN-1] <= vcol;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: horizontal replication at the row ends gives the window.
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] c0_2;
  logic [FW_W-1:0]  fw2;
  logic             last2;
  pix_t             win2 [SPAN][SPAN];

  always_comb begin
    for (int i = 0; i < SPAN; i++) begin
      win2[i][RADIUS] = colsh[RADIUS][i];
      for (int j = RADIUS - 1; j >= 0; j--) begin
        win2[i][j] = (int'(c0_2) + j < RADIUS) ? win2[i][j+1] : colsh[j][i];
      end
      for (int j = RADIUS + 1; j < SPAN; j++) begin
        win2[i][j] = (int'(c0_2) + j >= int'(fw2) + RADIUS) ? win2[i][j-1] : colsh[j][i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: constant-coefficient row sums for both large masks, and the
  // three small-mask sums over the centre of the window.
  // ---------------------------------------------------------------------
  pix_t win3 [SPAN][SPAN];
  logic last3;
  sum_t log_rs [SPAN];
  sum_t dog_rs [SPAN];
  sum_t sm_s   [3];

  always_comb begin
    int acc_log;
    int acc_dog;
    int acc_sm;
    for (int i = 0; i < SPAN; i++) begin
      acc_log = 0;
      acc_dog = 0;
      for (int j = 0; j < SPAN; j++) begin
        acc_log = acc_log + log_coef(i, j) * int'(win3[i][j]);
        acc_dog = acc_dog + dog_coef(i, j) * int'(win3[i][j]);
      end
      log_rs[i] = sum_t'(acc_log);
      dog_rs[i] = sum_t'(acc_dog);
    end
    for (int m = 0; m < 3; m++) begin
      acc_sm = 0;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          acc_sm = acc_sm + SMALL_MASK[m][a][b] * int'(win3[RADIUS-1+a][RADIUS-1+b]);
        end
      end
      sm_s[m] = sum_t'(acc_sm);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: add the row sums and pick the response of the active mode.
  // ---------------------------------------------------------------------
  sum_t log4 [SPAN];
  sum_t dog4 [SPAN];
  sum_t sm4  [3];
  logic last4;
  sum_t sum4;

  always_comb begin
    sum_t s_log;
    sum_t s_dog;
    s_log = '0;
    s_dog = '0;
    for (int i = 0; i < SPAN; i++) begin
      s_log = s_log + log4[i];
      s_dog = s_dog + dog4[i];
    end
    unique case (m_eff)
      MODE_FOUR:   sum4 = sm4[0];
      MODE_EIGHT:  sum4 = sm4[1];
      MODE_MINVAR: sum4 = sm4[2];
      MODE_LOG:    sum4 = s_log;
      MODE_DOG:    sum4 = s_dog;
      default:     sum4 = sm4[0];
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage 5: threshold compare. The divide-by-three modes compare against
  // three times the threshold, which is exact in integers. Only the
  // difference-of-Gaussians mode gives white above the threshold.
  // ---------------------------------------------------------------------
  sum_t sum5;
  logic last5;
  sum_t thr_s, thr_cmp;
  logic above;

  always_comb begin
    thr_s = sum_t'($signed(thr_r));
    if ((m_eff == MODE_EIGHT) || (m_eff == MODE_MINVAR)) begin
      thr_cmp = thr_s + (thr_s <<< 1);
    end else begin
      thr_cmp = thr_s;
    end
    above   = sum5 > thr_cmp;
    r_white = (m_eff == MODE_DOG) ? above : !above;
    r_last  = last5;
  end

  // Datapath payload registers; they move only with en.
  always_ff @(posedge clk) begin
    if (en) begin
      pix1  <= pixels.pixel;
      gcol1 <= gen_col;
      grow1 <= gen_row;
      c0_1  <= out_col;
      fw1   <= fw_use;
      fh1   <= fh_use;
      last1 <= frame_last;

      c0_2  <= c0_1;
      fw2   <= fw1;
      last2 <= last1;

      win3  <= win2;
      last3 <= last2;

      log4  <= log_rs;
      dog4  <= dog_rs;
      sm4   <= sm_s;
      last4 <= last3;

      sum5  <= sum4;
      last5 <= last4;
    end
  end

  // Output register with skid: a result arriving while the held one is
  // stalled parks in the skid, and the datapath holds until it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (ov && !edges.ready) begin
      if (en && v5) begin
        sv <= 1'b1;
      end
    end else if (sv) begin
      ov <= 1'b1;
      sv <= 1'b0;
    end else begin
      ov <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ov && !edges.ready) begin
      if (en && v5) begin
        sd_white <= r_white;
        sd_last  <= r_last;
      end
    end else if (sv) begin
      od_white <= sd_white;
      od_last  <= sd_last;
    end else begin
      od_white <= r_white;
      od_last  <= r_last;
    end
  end

endmodule

`default_nettype wire
